### rtl/core/hdrtm_pkg.sv
package hdrtm_pkg;

  localparam int CH_W   = 24;
  localparam int COEF_W = 16;
  localparam int PEAK_W = 22;
  localparam int REG_W  = 48;

  // divider geometry: numerator, divisor and quotient magnitude widths
  localparam int NUM_W = 54;
  localparam int DEN_W = 34;
  localparam int QUO_W = 30;

  // floor(x / 10) = (x * KNEE_RECIP) >> KNEE_SHIFT for x < 2**26
  localparam logic [25:0] KNEE_RECIP = 26'd53687092;
  localparam int          KNEE_SHIFT = 29;

  // positions of the valid bits along the pipeline
  localparam int ST_S6  = 5 + QUO_W;
  localparam int ST_S9  = 8 + 2 * QUO_W;
  localparam int ST_S12 = 11 + 2 * QUO_W;
  localparam int N_ST   = 17 + 3 * QUO_W;

  typedef enum logic [2:0] {
    REG_TO_ROW0   = 3'd0,
    REG_TO_ROW1   = 3'd1,
    REG_TO_ROW2   = 3'd2,
    REG_FROM_ROW0 = 3'd3,
    REG_FROM_ROW1 = 3'd4,
    REG_FROM_ROW2 = 3'd5,
    REG_LUMA      = 3'd6,
    REG_PEAK      = 3'd7
  } reg_idx_e;

  function automatic logic signed [COEF_W-1:0] coef(input logic [REG_W-1:0] r, input int k);
    return $signed(r[COEF_W*k +: COEF_W]);
  endfunction

endpackage

### rtl/core/hdrtm_div.sv
module hdrtm_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [hdrtm_pkg::NUM_W-1:0]        num_i,
  input  logic [hdrtm_pkg::DEN_W-1:0]        den_i,
  input  logic                               neg_i,
  output logic signed [hdrtm_pkg::QUO_W:0]   quo_o
);

  logic [hdrtm_pkg::DEN_W-1:0] rem_q [hdrtm_pkg::QUO_W];
  logic [hdrtm_pkg::QUO_W-1:0] acc_q [hdrtm_pkg::QUO_W];
  logic [hdrtm_pkg::DEN_W-1:0] den_q [hdrtm_pkg::QUO_W];
  logic                        neg_q [hdrtm_pkg::QUO_W];

  // one quotient bit a stage; acc shifts numerator bits out and quotient bits in
  for (genvar k = 0; k < hdrtm_pkg::QUO_W; k++) begin : g_stage
    logic [hdrtm_pkg::DEN_W-1:0] rem_in;
    logic [hdrtm_pkg::QUO_W-1:0] acc_in;
    logic [hdrtm_pkg::DEN_W-1:0] den_in;
    logic                        neg_in;
    logic [hdrtm_pkg::DEN_W:0]   trial;
    logic [hdrtm_pkg::DEN_W:0]   diff;
    logic                        ge;

    if (k == 0) begin : g_first
      assign rem_in = hdrtm_pkg::DEN_W'(num_i[hdrtm_pkg::NUM_W-1:hdrtm_pkg::QUO_W]);
      assign acc_in = num_i[hdrtm_pkg::QUO_W-1:0];
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign trial = {rem_in, acc_in[hdrtm_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[hdrtm_pkg::DEN_W-1:0] : trial[hdrtm_pkg::DEN_W-1:0];
        acc_q[k] <= {acc_in[hdrtm_pkg::QUO_W-2:0], ge};
        den_q[k] <= den_in;
        neg_q[k] <= neg_in;
      end
    end
  end

  assign quo_o = neg_q[hdrtm_pkg::QUO_W-1]
               ? -$signed({1'b0, acc_q[hdrtm_pkg::QUO_W-1]})
               : $signed({1'b0, acc_q[hdrtm_pkg::QUO_W-1]});

endmodule

### rtl/core/hdr_tone_map_gamut_clip_core.sv
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: in_red, in_green, in_blue
// m_axis    out  tvalid/tready          tdata: out_red, out_green, out_blue
// apb       in   psel/penable/pready    8 registers at 8*i, 64-bit data
//
// One pixel per cycle while the output word is taken; 17 arithmetic stages plus three
// 30-stage restoring dividers: tone curve, luminance ratio, desaturation.
// The output register gates the whole pipeline: while a word waits there
// untaken, every stage holds and no input word is taken.
// Reset clears the valid bits and loads the default registers.
module hdr_tone_map_gamut_clip_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // in_red [23:0], in_green [47:24], in_blue [71:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_red [23:0], out_green [47:24], out_blue [71:48]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int QW = hdrtm_pkg::QUO_W;

  typedef struct packed {
    logic [2:0][28:0] t;
    logic [33:0]      lum;
    logic [21:0]      lin;
    logic             usediv;
  } a_side_t;

  typedef struct packed {
    logic [21:0] m;
    logic        lumpos;
  } b_side_t;

  typedef struct packed {
    logic [2:0][30:0] t;
    logic [21:0]      m;
    logic [2:0][21:0] cn;
    logic [2:0][30:0] cd;
    logic [2:0]       has;
    logic [21:0]      num;
    logic [30:0]      den;
    logic             lumpos;
  } ch_t;

  // ---------------- registers ----------------
  logic [47:0] to_q [3];
  logic [47:0] from_q [3];
  logic [47:0] luma_q;
  logic [21:0] peak_q;
  hdrtm_pkg::reg_idx_e idx;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = hdrtm_pkg::reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      to_q[0]   <= 48'd8192;
      to_q[1]   <= 48'd536870912;
      to_q[2]   <= 48'd35184372088832;
      from_q[0] <= 48'd8192;
      from_q[1] <= 48'd536870912;
      from_q[2] <= 48'd35184372088832;
      luma_q    <= 48'd2538709649102;
      peak_q    <= 22'd51968;
    end else if (wr) begin
      unique case (idx)
        hdrtm_pkg::REG_TO_ROW0:   to_q[0]   <= pwdata[47:0];
        hdrtm_pkg::REG_TO_ROW1:   to_q[1]   <= pwdata[47:0];
        hdrtm_pkg::REG_TO_ROW2:   to_q[2]   <= pwdata[47:0];
        hdrtm_pkg::REG_FROM_ROW0: from_q[0] <= pwdata[47:0];
        hdrtm_pkg::REG_FROM_ROW1: from_q[1] <= pwdata[47:0];
        hdrtm_pkg::REG_FROM_ROW2: from_q[2] <= pwdata[47:0];
        hdrtm_pkg::REG_LUMA:      luma_q    <= pwdata[47:0];
        hdrtm_pkg::REG_PEAK:      peak_q    <= pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hdrtm_pkg::REG_TO_ROW0:   prdata = {16'b0, to_q[0]};
      hdrtm_pkg::REG_TO_ROW1:   prdata = {16'b0, to_q[1]};
      hdrtm_pkg::REG_TO_ROW2:   prdata = {16'b0, to_q[2]};
      hdrtm_pkg::REG_FROM_ROW0: prdata = {16'b0, from_q[0]};
      hdrtm_pkg::REG_FROM_ROW1: prdata = {16'b0, from_q[1]};
      hdrtm_pkg::REG_FROM_ROW2: prdata = {16'b0, from_q[2]};
      hdrtm_pkg::REG_LUMA:      prdata = {16'b0, luma_q};
      hdrtm_pkg::REG_PEAK:      prdata = {42'b0, peak_q};
      default:                  prdata = '0;
    endcase
  end

  // knee and headroom follow the peak register
  logic [25:0] peak9;
  logic [51:0] knee_prod;
  logic [21:0] knee_q, h_q;
  logic [43:0] hh_q;

  assign peak9     = {4'b0, peak_q} * 26'd9;
  assign knee_prod = {26'b0, peak9} * {26'b0, hdrtm_pkg::KNEE_RECIP};

  always_ff @(posedge clk_i) begin
    knee_q <= knee_prod[hdrtm_pkg::KNEE_SHIFT +: 22];
    h_q    <= peak_q - knee_q;
    hh_q   <= {22'b0, h_q} * {22'b0, h_q};
  end

  // ---------------- flow control ----------------
  logic                      en;
  logic [hdrtm_pkg::N_ST-1:0] v_q;

  assign en            = !v_q[hdrtm_pkg::N_ST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[hdrtm_pkg::N_ST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[hdrtm_pkg::N_ST-2:0], s_axis_tvalid};
    end
  end

  // ---------------- forward matrix ----------------
  logic signed [23:0] cin [3];
  logic signed [39:0] p1_q [3][3];
  logic signed [41:0] s2_sum [3];
  logic signed [28:0] t2_q [3];
  logic signed [44:0] p3_q [3];
  logic signed [28:0] t3_q [3];
  logic signed [46:0] s4_sum;
  logic signed [33:0] lum4_q;
  logic signed [28:0] t4_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cin[k] = $signed(s_axis_tdata[24*k +: 24]);
    end
    for (int i = 0; i < 3; i++) begin
      s2_sum[i] = 42'(p1_q[i][0]) + 42'(p1_q[i][1]) + 42'(p1_q[i][2]) + 42'sd4096;
    end
    s4_sum = 47'(p3_q[0]) + 47'(p3_q[1]) + 47'(p3_q[2]) + 47'sd4096;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p1_q[i][k] <= hdrtm_pkg::coef(to_q[i], k) * cin[k];
        end
        t2_q[i] <= s2_sum[i][41:13];
        p3_q[i] <= hdrtm_pkg::coef(luma_q, i) * t2_q[i];
        t3_q[i] <= t2_q[i];
        t4_q[i] <= t3_q[i];
      end
      lum4_q <= s4_sum[46:13];
    end
  end

  // ---------------- tone curve ----------------
  logic [32:0] v5;
  logic        usediv5;
  logic [21:0] lin5;
  logic [33:0] da5;
  logic [53:0] na5;
  logic [53:0] na5_q;
  logic [33:0] da5_q;
  a_side_t     s5_q;
  a_side_t     sa_q [QW];
  logic signed [QW:0] quo_a;

  always_comb begin
    v5      = lum4_q[33] ? 33'd0 : lum4_q[32:0];
    usediv5 = (v5 > {11'b0, knee_q}) && (peak_q > knee_q);
    lin5    = (v5 < {11'b0, peak_q}) ? v5[21:0] : peak_q;
    da5     = {1'b0, v5} - {12'b0, knee_q} + {12'b0, h_q};
    na5     = {10'b0, hh_q} + {21'b0, da5[33:1]};
    if (!usediv5) begin
      da5 = 34'd1;
      na5 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na5_q <= na5;
      da5_q <= da5;
      for (int k = 0; k < 3; k++) begin
        s5_q.t[k] <= t4_q[k];
      end
      s5_q.lum    <= lum4_q;
      s5_q.lin    <= lin5;
      s5_q.usediv <= usediv5;
      sa_q[0]     <= s5_q;
      for (int j = 1; j < QW; j++) begin
        sa_q[j] <= sa_q[j-1];
      end
    end
  end

  hdrtm_div u_div_tone (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (na5_q),
    .den_i (da5_q),
    .neg_i (1'b0),
    .quo_o (quo_a)
  );

  // ---------------- luminance ratio ----------------
  logic signed [28:0] t6_q [3];
  logic signed [33:0] lum6_q, lum7_q;
  logic [21:0]        m6_q, m7_q;
  logic [28:0]        tabs7 [3];
  logic [50:0]        p7_q [3];
  logic               neg7_q [3];
  logic               lumpos8;
  logic [53:0]        nb8_q [3];
  logic [33:0]        db8_q;
  logic               negb8_q [3];
  b_side_t            sb8_q;
  b_side_t            sb_q [QW];
  logic signed [QW:0] quo_b [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tabs7[k] = t6_q[k][28] ? 29'(-t6_q[k]) : 29'(t6_q[k]);
    end
    lumpos8 = !lum7_q[33] && (lum7_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t6_q[k]    <= $signed(sa_q[QW-1].t[k]);
        p7_q[k]    <= {22'b0, tabs7[k]} * {29'b0, m6_q};
        neg7_q[k]  <= t6_q[k][28];
        nb8_q[k]   <= lumpos8 ? ({3'b0, p7_q[k]} + {21'b0, lum7_q[33:1]}) : '0;
        negb8_q[k] <= neg7_q[k];
      end
      lum6_q       <= $signed(sa_q[QW-1].lum);
      m6_q         <= sa_q[QW-1].usediv ? peak_q - quo_a[21:0] : sa_q[QW-1].lin;
      lum7_q       <= lum6_q;
      m7_q         <= m6_q;
      db8_q        <= lumpos8 ? lum7_q : 34'd1;
      sb8_q.m      <= lumpos8 ? m7_q : '0;
      sb8_q.lumpos <= lumpos8;
      sb_q[0]      <= sb8_q;
      for (int j = 1; j < QW; j++) begin
        sb_q[j] <= sb_q[j-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div_ratio
    hdrtm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nb8_q[k]),
      .den_i (db8_q),
      .neg_i (negb8_q[k]),
      .quo_o (quo_b[k])
    );
  end

  // ---------------- desaturation factor ----------------
  logic signed [31:0] tb32 [3];
  logic signed [31:0] m32, p32;
  logic signed [31:0] cdx [3];
  ch_t                ch0_d;
  ch_t                ch_d [3];
  ch_t                ch_q [4];
  logic [52:0]        lhs [3];
  logic [52:0]        rhs [3];

  always_comb begin
    m32          = $signed({10'b0, sb_q[QW-1].m});
    p32          = $signed({10'b0, peak_q});
    ch0_d        = '0;
    ch0_d.m      = sb_q[QW-1].m;
    ch0_d.lumpos = sb_q[QW-1].lumpos;
    ch0_d.num    = 22'd1;
    ch0_d.den    = 31'd1;
    for (int k = 0; k < 3; k++) begin
      tb32[k]    = 32'(quo_b[k]);
      ch0_d.t[k] = quo_b[k];
      cdx[k]     = '0;
      if (tb32[k] < 0) begin
        ch0_d.has[k] = 1'b1;
        ch0_d.cn[k]  = sb_q[QW-1].m;
        cdx[k]       = m32 - tb32[k];
      end else if (tb32[k] > p32) begin
        ch0_d.has[k] = 1'b1;
        ch0_d.cn[k]  = peak_q - sb_q[QW-1].m;
        cdx[k]       = tb32[k] - m32;
      end
      ch0_d.cd[k] = cdx[k][30:0];
    end
    // keep the smaller fraction, one channel a stage
    for (int j = 0; j < 3; j++) begin
      ch_d[j] = ch_q[j];
      lhs[j]  = 53'(ch_q[j].cn[j]) * 53'(ch_q[j].den);
      rhs[j]  = 53'(ch_q[j].num) * 53'(ch_q[j].cd[j]);
      if (ch_q[j].has[j] && (lhs[j] < rhs[j])) begin
        ch_d[j].num = ch_q[j].cn[j];
        ch_d[j].den = ch_q[j].cd[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch_q[0] <= ch0_d;
      for (int j = 0; j < 3; j++) begin
        ch_q[j+1] <= ch_d[j];
      end
    end
  end

  // ---------------- blend toward luminance ----------------
  logic signed [31:0] diff13 [3];
  logic [30:0]        abs13 [3];
  logic [52:0]        p13_q [3];
  logic               neg13_q [3];
  logic [30:0]        den13_q;
  logic [21:0]        m13_q;
  logic [53:0]        nc14_q [3];
  logic [33:0]        dc14_q;
  logic               negc14_q [3];
  logic [21:0]        m14_q;
  logic [21:0]        sc_q [QW];
  logic signed [QW:0] quo_c [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff13[k] = 32'($signed(ch_q[3].t[k])) - $signed({10'b0, ch_q[3].m});
      abs13[k]  = diff13[k][31] ? 31'(-diff13[k]) : diff13[k][30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p13_q[k]    <= {22'b0, abs13[k]} * {31'b0, ch_q[3].num};
        neg13_q[k]  <= diff13[k][31];
        nc14_q[k]   <= {1'b0, p13_q[k]} + {24'b0, den13_q[30:1]};
        negc14_q[k] <= neg13_q[k];
      end
      den13_q <= ch_q[3].den;
      m13_q   <= ch_q[3].m;
      dc14_q  <= {3'b0, den13_q};
      m14_q   <= m13_q;
      sc_q[0] <= m14_q;
      for (int j = 1; j < QW; j++) begin
        sc_q[j] <= sc_q[j-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div_blend
    hdrtm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nc14_q[k]),
      .den_i (dc14_q),
      .neg_i (negc14_q[k]),
      .quo_o (quo_c[k])
    );
  end

  // ---------------- back matrix and saturation ----------------
  logic signed [31:0] t15_q [3];
  logic signed [47:0] p16_q [3][3];
  logic signed [49:0] s17_sum [3];
  logic signed [36:0] o17 [3];
  logic [23:0]        out_d [3];
  logic [23:0]        out_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s17_sum[i] = 50'(p16_q[i][0]) + 50'(p16_q[i][1]) + 50'(p16_q[i][2]) + 50'sd4096;
      o17[i]     = s17_sum[i][49:13];
      if (o17[i] > 37'sd8388607) begin
        out_d[i] = 24'h7FFFFF;
      end else if (o17[i] < -37'sd8388608) begin
        out_d[i] = 24'h800000;
      end else begin
        out_d[i] = o17[i][23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t15_q[k] <= 32'(quo_c[k]) + $signed({10'b0, sc_q[QW-1]});
      end
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          p16_q[i][k] <= hdrtm_pkg::coef(from_q[i], k) * t15_q[k];
        end
        out_q[i] <= out_d[i];
      end
    end
  end

  assign m_axis_tdata = {out_q[2], out_q[1], out_q[0]};

  // ---------------- assertions ----------------
  a_map_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[hdrtm_pkg::ST_S6] |-> (m6_q <= peak_q))
    else $error("mapped luminance above peak");

  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[hdrtm_pkg::ST_S9] && !ch_q[0].lumpos) |->
      (ch_q[0].t == '0 && ch_q[0].m == '0))
    else $error("dark pixel not cleared");

  a_factor_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[hdrtm_pkg::ST_S12] |-> ({9'b0, ch_q[3].num} <= ch_q[3].den && ch_q[3].den != '0))
    else $error("desaturation factor above one");

endmodule
